/* design/adts_pkg.sv */
// Shared types and constants for the ADTS header deframer.
package adts_pkg;

	localparam int unsigned HDR_W = 48;
	localparam int unsigned CRC_W = 16;
	localparam int unsigned LEN_W = 13;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOSYNC = 2'd1;
	localparam logic [1:0] ST_SHORT  = 2'd2;

	localparam logic [7:0] SYNC_BYTE   = 8'hff;
	localparam logic [3:0] SYNC_NIBBLE = 4'hf;

	localparam logic [LEN_W-1:0] OVH_NO_CRC = 13'd7;
	localparam logic [LEN_W-1:0] OVH_CRC    = 13'd9;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_CRC     = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_HALT    = 4'b1000
	} adts_phase_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             mpeg_id;
		logic [1:0]       layer_bits;
		logic             protection_absent;
		logic [1:0]       profile;
		logic [3:0]       freq_index;
		logic [2:0]       channel_config;
		logic [4:0]       misc_flags;
		logic [LEN_W-1:0] payload_len;
		logic [10:0]      buffer_fullness;
		logic [1:0]       raw_blocks;
		logic [15:0]      header_crc;
	} adts_result_t;

endpackage

/* design/adts_header_deframer.sv */
// Top level of the ADTS header deframer: input stage, parser, result register.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------------------
//  input     | data_valid / data_stall      | data_byte (8)
//  result    | result_valid / result_stall  | status .. header_crc (12 fields)
//
// One byte item is accepted per cycle while data_stall is low; the result for
// the byte that completes a header (or CRC, or fails sync) passes from the
// input register through the single parse step into the result register, and
// a stalled result in the result register holds the parse step in between.
// Reset (arst_n low) returns to header collection with parser state and valid flags cleared.
// A held result under result_stall freezes the parser; one byte still lands
// in the input register before data_stall rises.
module adts_header_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic        mpeg_id,
	output logic [1:0]  layer_bits,
	output logic        protection_absent,
	output logic [1:0]  profile,
	output logic [3:0]  freq_index,
	output logic [2:0]  channel_config,
	output logic [4:0]  misc_flags,
	output logic [12:0] payload_len,
	output logic [10:0] buffer_fullness,
	output logic [1:0]  raw_blocks,
	output logic [15:0] header_crc
);
	import adts_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_q;
	adts_result_t out_q;
	logic         out_block;
	logic         step;
	logic         emit;
	adts_result_t res;

	// the result slot is busy only while a result sits there and is stalled
	assign out_block  = out_valid_q && result_stall;
	assign data_stall = valid_s1 && out_block;
	assign step       = valid_s1 && !out_block;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

	adts_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.emit    (emit),
		.result  (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign result_valid      = out_valid_q;
	assign status            = out_q.status;
	assign mpeg_id           = out_q.mpeg_id;
	assign layer_bits        = out_q.layer_bits;
	assign protection_absent = out_q.protection_absent;
	assign profile           = out_q.profile;
	assign freq_index        = out_q.freq_index;
	assign channel_config    = out_q.channel_config;
	assign misc_flags        = out_q.misc_flags;
	assign payload_len       = out_q.payload_len;
	assign buffer_fullness   = out_q.buffer_fullness;
	assign raw_blocks        = out_q.raw_blocks;
	assign header_crc        = out_q.header_crc;

endmodule

/* design/adts_fields.sv */
// Header field decode and payload length computation.
module adts_fields (
	input  logic [adts_pkg::HDR_W-1:0] hdr,
	input  logic [adts_pkg::CRC_W-1:0] crc,
	output adts_pkg::adts_result_t     result
);
	import adts_pkg::*;

	logic [7:0]       b1, b2, b3, b4, b5, b6;
	logic [LEN_W-1:0] flen;
	logic [LEN_W-1:0] overhead;
	logic             short_frame;

	assign b1 = hdr[47:40];
	assign b2 = hdr[39:32];
	assign b3 = hdr[31:24];
	assign b4 = hdr[23:16];
	assign b5 = hdr[15:8];
	assign b6 = hdr[7:0];

	assign flen        = {b3[1:0], b4, b5[7:5]};
	assign overhead    = b1[0] ? OVH_NO_CRC : OVH_CRC;
	assign short_frame = flen < overhead;

	always_comb begin
		result.status            = short_frame ? ST_SHORT : ST_OK;
		result.mpeg_id           = b1[3];
		result.layer_bits        = b1[2:1];
		result.protection_absent = b1[0];
		result.profile           = b2[7:6];
		result.freq_index        = b2[5:2];
		result.channel_config    = {b2[0], b3[7:6]};
		result.misc_flags        = {b2[1], b3[5:2]};
		result.payload_len       = short_frame ? '0 : flen - overhead;
		result.buffer_fullness   = {b5[4:0], b6[7:2]};
		result.raw_blocks        = b6[1:0];
		result.header_crc        = b1[0] ? '0 : crc;
	end

endmodule

/* design/adts_parser.sv */
// Frame phase tracking, header/CRC collection and payload skipping.
module adts_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            byte_in,
	output logic                  emit,
	output adts_pkg::adts_result_t result
);
	import adts_pkg::*;

	adts_phase_t       phase_q, phase_d;
	logic [2:0]        cnt_q, cnt_d;
	logic [HDR_W-1:0]  hdr_q, hdr_d;
	logic [CRC_W-1:0]  crc_q, crc_d;
	logic [LEN_W-1:0]  left_q, left_d;
	logic [HDR_W-1:0]  hdr_shift;
	logic [HDR_W-1:0]  hdr_dec;
	logic [CRC_W-1:0]  crc_shift;
	logic [CRC_W-1:0]  crc_dec;
	adts_result_t      dec;

	assign hdr_shift = {hdr_q[HDR_W-9:0], byte_in};
	assign crc_shift = {crc_q[CRC_W-9:0], byte_in};
	// decode sees the header as it will be after this byte
	assign hdr_dec   = (phase_q == PH_HEADER) ? hdr_shift : hdr_q;
	// CRC is only meaningful once the CRC phase has run
	assign crc_dec   = (phase_q == PH_CRC) ? crc_shift : '0;

	adts_fields u_fields (
		.hdr    (hdr_dec),
		.crc    (crc_dec),
		.result (dec)
	);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		hdr_d   = hdr_q;
		crc_d   = crc_q;
		left_d  = left_q;
		emit    = 1'b0;
		result  = dec;
		case (phase_q)
			PH_HEADER: begin
				hdr_d = hdr_shift;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd1 &&
				    (hdr_q[7:0] != SYNC_BYTE || byte_in[7:4] != SYNC_NIBBLE)) begin
					emit    = step;
					result  = '0;
					result.status = ST_NOSYNC;
					phase_d = PH_HALT;
				end else if (cnt_q == 3'd6) begin
					cnt_d = '0;
					crc_d = '0;
					if (hdr_shift[40]) begin
						emit    = step;
						left_d  = dec.payload_len;
						phase_d = (dec.payload_len != '0) ? PH_PAYLOAD : PH_HEADER;
					end else begin
						phase_d = PH_CRC;
					end
				end
			end
			PH_CRC: begin
				crc_d = crc_shift;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd1) begin
					emit    = step;
					cnt_d   = '0;
					left_d  = dec.payload_len;
					phase_d = (dec.payload_len != '0) ? PH_PAYLOAD : PH_HEADER;
				end
			end
			PH_PAYLOAD: begin
				if (left_q <= 13'd1) begin
					left_d  = '0;
					cnt_d   = '0;
					phase_d = PH_HEADER;
				end else begin
					left_d = left_q - 13'd1;
				end
			end
			PH_HALT: begin
			end
			default: begin
				phase_d = PH_HALT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			hdr_q   <= '0;
			crc_q   <= '0;
			left_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			hdr_q   <= hdr_d;
			crc_q   <= crc_d;
			left_q  <= left_d;
		end
	end

endmodule
